// File: rtl/core/amvi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amvi_pkg
// Table, widths and constants shared by the converter-to-millivolt pipeline.
// ----------------------------------------------------------------------------
package amvi_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int AXIS_POINTS  = 13;
  localparam int SEGMENTS     = AXIS_POINTS - 1;
  localparam int SEG_W        = $clog2(SEGMENTS);
  localparam int AXIS_W       = 10;   // bits of the largest breakpoint count
  localparam int SLOPE_W      = 15;   // slope in 0.001 mV per count
  localparam int MV_W         = 16;
  localparam int DV_W         = 8;
  localparam int SLOPE_SCALE  = 1000;
  localparam int DECI_DIV     = 100;
  localparam int MV_MAX       = 65535;
  localparam int DV_MAX       = 255;

  localparam logic [15:0] AXIS_COUNT [AXIS_POINTS] = '{
    16'd247, 16'd285, 16'd324, 16'd362, 16'd400, 16'd438, 16'd476,
    16'd514, 16'd552, 16'd590, 16'd628, 16'd666, 16'd705
  };

  localparam logic [MV_W-1:0] AXIS_MV [AXIS_POINTS] = '{
    16'd7000,  16'd8000,  16'd9000,  16'd10000, 16'd11000, 16'd12000, 16'd13000,
    16'd14000, 16'd15000, 16'd16000, 16'd17000, 16'd18000, 16'd19000
  };

  // (dy * 1000) / dx, truncated; dx is 38 counts except 39 on two segments
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEGMENTS] = '{
    15'd26315, 15'd25641, 15'd26315, 15'd26315, 15'd26315, 15'd26315,
    15'd26315, 15'd26315, 15'd26315, 15'd26315, 15'd26315, 15'd25641
  };

endpackage
`default_nettype wire

// File: rtl/core/amvi_segment.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amvi_segment
// Segment select, breakpoint lookup and signed offset from the segment start.
// ----------------------------------------------------------------------------
module amvi_segment
  import amvi_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [ADC_BITS-1:0]             adc_i,
  output logic                                 valid_o,
  output logic signed [((ADC_BITS > AXIS_W) ? ADC_BITS : AXIS_W):0] delta_o,
  output logic [SLOPE_W-1:0]                   slope_o,
  output logic [MV_W-1:0]                      y0_o
);

  localparam int XW = (ADC_BITS > AXIS_W) ? ADC_BITS : AXIS_W;
  localparam int DW = XW + 1;

  logic [XW-1:0]    adc_x;
  logic [SEG_W-1:0] seg_d, seg_q;
  logic [XW-1:0]    adc_q;
  logic             v1_q;
  logic [XW-1:0]    x0;
  logic signed [DW-1:0] delta_d;

  assign adc_x = XW'(adc_i);

  // highest breakpoint at or below the count; first/last segments extend
  always_comb begin
    seg_d = '0;
    for (int k = 1; k < SEGMENTS; k++) begin
      if (adc_x >= AXIS_COUNT[k][XW-1:0]) begin
        seg_d = SEG_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    adc_q <= adc_x;
  end

  assign x0      = AXIS_COUNT[seg_q][XW-1:0];
  assign delta_d = $signed({1'b0, adc_q}) - $signed({1'b0, x0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_o <= delta_d;
    slope_o <= SEG_SLOPE[seg_q];
    y0_o    <= AXIS_MV[seg_q];
  end

`ifndef SYNTHESIS
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (32'(seg_q) < SEGMENTS) && ((seg_q == '0) || (adc_q >= x0)))
    else $error("segment select out of order");
`endif

endmodule
`default_nettype wire

// File: rtl/core/amvi_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amvi_scale
// Offset times slope, then divide by 1000 toward zero by reciprocal multiply
// split into two partial products.
// ----------------------------------------------------------------------------
module amvi_scale
  import amvi_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic signed [((ADC_BITS > AXIS_W) ? ADC_BITS : AXIS_W):0] delta_i,
  input  wire logic [SLOPE_W-1:0]              slope_i,
  input  wire logic [MV_W-1:0]                 y0_i,
  output logic                                 valid_o,
  output logic                                 neg_o,
  output logic [((ADC_BITS > AXIS_W) ? ADC_BITS : AXIS_W) + SLOPE_W - 10:0] quot_o,
  output logic [MV_W-1:0]                      y0_o
);

  localparam int XW  = (ADC_BITS > AXIS_W) ? ADC_BITS : AXIS_W;
  localparam int DW  = XW + 1;
  localparam int PW  = DW + SLOPE_W + 1;
  localparam int N   = XW + SLOPE_W;          // magnitude bits of the product
  localparam int QW  = N - 9;
  localparam int K   = N + 10;
  localparam int MW  = N + 1;
  localparam int MLW = MW / 2;
  localparam int MHW = MW - MLW;
  localparam int PLW = N + MLW;
  localparam int PHW = N + MHW;
  localparam int SUW = N + MW + 1;
  localparam logic [63:0] MAGIC = ((64'd1 << K) + 64'd999) / 64'd1000;
  localparam logic [MLW-1:0] MAGIC_LO = MAGIC[MLW-1:0];
  localparam logic [MHW-1:0] MAGIC_HI = MAGIC[MW-1:MLW];

  logic signed [PW-1:0] prod_q;
  logic [MV_W-1:0]      y0_3_q, y0_4_q;
  logic                 v3_q, v4_q;
  logic                 neg_d, neg4_q;
  logic [PW-1:0]        mag_full;
  logic [N-1:0]         mag;
  logic [PLW-1:0]       pp_lo_q;
  logic [PHW-1:0]       pp_hi_q;
  logic [SUW-1:0]       pp_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v3_q    <= valid_i;
      v4_q    <= v3_q;
      valid_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(delta_i) * $signed({1'b0, slope_i});
    y0_3_q <= y0_i;
  end

  assign neg_d    = prod_q[PW-1];
  assign mag_full = neg_d ? (~prod_q + 1'b1) : prod_q;
  assign mag      = mag_full[N-1:0];

  always_ff @(posedge clk_i) begin
    pp_lo_q <= PLW'(mag) * PLW'(MAGIC_LO);
    pp_hi_q <= PHW'(mag) * PHW'(MAGIC_HI);
    neg4_q  <= neg_d;
    y0_4_q  <= y0_3_q;
  end

  assign pp_sum = (SUW'(pp_hi_q) << MLW) + SUW'(pp_lo_q);

  always_ff @(posedge clk_i) begin
    quot_o <= pp_sum[K+QW-1:K];
    neg_o  <= neg4_q;
    y0_o   <= y0_4_q;
  end

endmodule
`default_nettype wire

// File: rtl/core/amvi_output.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amvi_output
// Adds the segment base, clamps to the millivolt range and derives the
// decivolt value by reciprocal multiply, saturated.
// ----------------------------------------------------------------------------
module amvi_output
  import amvi_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic                            neg_i,
  input  wire logic [((ADC_BITS > AXIS_W) ? ADC_BITS : AXIS_W) + SLOPE_W - 10:0] quot_i,
  input  wire logic [MV_W-1:0]                 y0_i,
  output logic                                 valid_o,
  output logic [MV_W-1:0]                      mv_o,
  output logic [DV_W-1:0]                      dv_o
);

  localparam int XW  = (ADC_BITS > AXIS_W) ? ADC_BITS : AXIS_W;
  localparam int QW  = XW + SLOPE_W - 9;
  localparam int SMW = ((QW > MV_W) ? QW : MV_W) + 2;
  localparam int DK  = MV_W + 7;
  localparam int DMW = MV_W + 1;
  localparam int DPW = MV_W + DMW;
  localparam int DQW = DPW - DK;
  localparam logic [63:0] DMAGIC64 = ((64'd1 << DK) + 64'd99) / 64'd100;
  localparam logic [DMW-1:0] DMAGIC = DMAGIC64[DMW-1:0];

  logic signed [SMW-1:0] qs, mv_sum;
  logic [MV_W-1:0]       mv_d, mv6_q, mv7_q;
  logic                  v6_q, v7_q;
  logic [DPW-1:0]        dprod_q;
  logic [DQW-1:0]        dq;

  assign qs     = neg_i ? -$signed(SMW'(quot_i)) : $signed(SMW'(quot_i));
  assign mv_sum = qs + $signed(SMW'(y0_i));

  always_comb begin
    if (mv_sum < 0) begin
      mv_d = '0;
    end else if (mv_sum > $signed(SMW'(MV_MAX))) begin
      mv_d = MV_W'(MV_MAX);
    end else begin
      mv_d = mv_sum[MV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v6_q    <= valid_i;
      v7_q    <= v6_q;
      valid_o <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mv6_q   <= mv_d;
    dprod_q <= DPW'(mv6_q) * DPW'(DMAGIC);
    mv7_q   <= mv6_q;
  end

  assign dq = dprod_q[DPW-1:DK];

  always_ff @(posedge clk_i) begin
    mv_o <= mv7_q;
    dv_o <= (dq > DQW'(DV_MAX)) ? DV_W'(DV_MAX) : dq[DV_W-1:0];
  end

`ifndef SYNTHESIS
  a_dv_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (dv_o != DV_W'(DV_MAX)) |->
      (17'(dv_o) * 17'(DECI_DIV) <= 17'(mv_o)) &&
      (17'(mv_o) < 17'(dv_o) * 17'(DECI_DIV) + 17'(DECI_DIV)))
    else $error("decivolt does not match millivolt");
  a_dv_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (dv_o == DV_W'(DV_MAX)) |-> 32'(mv_o) >= DV_MAX * DECI_DIV)
    else $error("decivolt saturated too early");
  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(v7_q))
    else $error("result beat without a source beat");
`endif

endmodule
`default_nettype wire

// File: rtl/core/adc_to_millivolt_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_to_millivolt_interpolator
// Battery converter count to millivolts by piecewise linear table lookup.
// ----------------------------------------------------------------------------
// Usage:
//   A count on adc_count_i is taken at each rising edge with start high;
//   busy stays low, so one count per cycle is accepted.
//   Each result appears on supply_millivolt_o / supply_decivolt_o for one
//   cycle with valid_o high; the receiver must take it in that cycle.
// Pipeline: 8 register stages (segment select, lookup, product, partial
//   products, quotient, clamp, decivolt product, output).
// Throughput: one beat per cycle, fixed by the fully pipelined datapath.
// Reset: rst_ni clears all valid bits; beats in flight are dropped, no
//   result is produced until a new count is accepted.
// Counts below the table extrapolate the first segment, counts at or above
//   the last point the last segment; millivolts clamp to 0..65535 and
//   decivolts saturate at 255.
// ----------------------------------------------------------------------------
module adc_to_millivolt_interpolator
  import amvi_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [ADC_BITS-1:0]   adc_count_i,
  output logic                       valid_o,
  output logic [MV_W-1:0]            supply_millivolt_o,
  output logic [DV_W-1:0]            supply_decivolt_o
);

  localparam int XW = (ADC_BITS > AXIS_W) ? ADC_BITS : AXIS_W;
  localparam int QW = XW + SLOPE_W - 9;

  logic                 seg_valid;
  logic signed [XW:0]   seg_delta;
  logic [SLOPE_W-1:0]   seg_slope;
  logic [MV_W-1:0]      seg_y0;
  logic                 scl_valid;
  logic                 scl_neg;
  logic [QW-1:0]        scl_quot;
  logic [MV_W-1:0]      scl_y0;

  assign busy = 1'b0;

  amvi_segment #(
    .ADC_BITS(ADC_BITS)
  ) u_segment (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .adc_i   (adc_count_i),
    .valid_o (seg_valid),
    .delta_o (seg_delta),
    .slope_o (seg_slope),
    .y0_o    (seg_y0)
  );

  amvi_scale #(
    .ADC_BITS(ADC_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (seg_valid),
    .delta_i (seg_delta),
    .slope_i (seg_slope),
    .y0_i    (seg_y0),
    .valid_o (scl_valid),
    .neg_o   (scl_neg),
    .quot_o  (scl_quot),
    .y0_o    (scl_y0)
  );

  amvi_output #(
    .ADC_BITS(ADC_BITS)
  ) u_output (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scl_valid),
    .neg_i   (scl_neg),
    .quot_i  (scl_quot),
    .y0_i    (scl_y0),
    .valid_o (valid_o),
    .mv_o    (supply_millivolt_o),
    .dv_o    (supply_decivolt_o)
  );

endmodule
`default_nettype wire
